### hdl/cq_pkg.sv
// Shared types, codes and helpers for the circular queue.
`default_nettype none

package cq_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] CMD_ENQ  = 2'd0;
  localparam logic [1:0] CMD_DEQ  = 2'd1;
  localparam logic [1:0] CMD_SIZE = 2'd2;
  localparam logic [1:0] CMD_TRAV = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [3:0]         occupancy;
    logic               last;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic       enq;         // store value at tail, count up
    logic       deq;         // advance head, count down
    logic       walk_start;  // begin a traverse from head
    logic       walk_step;   // move traverse pointer on
    logic       rd_en;       // fetch one entry into the read register
    logic       rd_walk;     // fetch at traverse pointer rather than head
    logic       load_out;    // load the output register
    logic       out_mem;     // output data from the read register
    logic [1:0] out_status;
    logic       out_last;
  } cq_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;
    logic full;
    logic walk_done;
    logic out_free;
  } cq_stat_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

  // Occupancy is reported in four bits, wrapping for deep queues
  function automatic logic [3:0] occ_of(input logic [CNT_W-1:0] cnt);
    logic [CNT_W+3:0] wide;
    wide = {4'b0000, cnt};
    return wide[3:0];
  endfunction

endpackage

`default_nettype wire

### hdl/cq_dp.sv
// Datapath: entry memory, head/tail/count, traverse pointer and output register.
`default_nettype none

module cq_dp import cq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cq_ctl_t            ctl,
  input  wire logic signed [31:0] value,
  output cq_stat_t                stat,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output result_t                 result
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rd_data;
  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   tail;
  logic [IDX_W-1:0]   walk;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   left;
  logic [IDX_W-1:0]   rd_addr;

  always_comb begin
    if (ctl.enq) begin
      count_next = count + CNT_W'(1);
    end else if (ctl.deq) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  assign rd_addr = ctl.rd_walk ? walk : head;

  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      mem[tail] <= value;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      walk  <= '0;
      left  <= '0;
    end else begin
      count <= count_next;
      if (ctl.enq) begin
        tail <= next_idx(tail);
      end
      if (ctl.deq) begin
        head <= next_idx(head);
        left <= '0;
      end
      if (ctl.walk_start) begin
        walk <= next_idx(head);
        left <= count - CNT_W'(1);
      end else if (ctl.walk_step) begin
        walk <= next_idx(walk);
        left <= left - CNT_W'(1);
      end
    end
  end

  // Output register: hold while stalled, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      result.status    <= ctl.out_status;
      result.data      <= ctl.out_mem ? rd_data : 32'sd0;
      result.occupancy <= occ_of(count_next);
      result.last      <= ctl.out_last;
    end
  end

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CNT_W'(DEPTH));
  assign stat.walk_done = (left == '0);
  assign stat.out_free  = !result_valid || !result_stall;

endmodule

`default_nettype wire

### hdl/cq_ctrl.sv
// Controller: decodes commands and sequences dequeue and traverse reads.
`default_nettype none

module cq_ctrl import cq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [1:0] cmd,
  input  wire cq_stat_t   stat,
  output cq_ctl_t         ctl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign item_stall = !((state == S_IDLE) && stat.out_free);
  assign take       = item_valid && !item_stall;

  always_comb begin
    ctl        = '0;
    ctl.out_status = ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          unique case (cmd)
            CMD_ENQ: begin
              ctl.enq        = !stat.full;
              ctl.load_out   = 1'b1;
              ctl.out_status = stat.full ? ST_OVERFLOW : ST_OK;
              ctl.out_last   = 1'b1;
            end
            CMD_DEQ: begin
              if (stat.empty) begin
                ctl.load_out   = 1'b1;
                ctl.out_status = ST_UNDERFLOW;
                ctl.out_last   = 1'b1;
              end else begin
                ctl.deq    = 1'b1;
                ctl.rd_en  = 1'b1;
                state_next = S_EMIT;
              end
            end
            CMD_SIZE: begin
              ctl.load_out = 1'b1;
              ctl.out_last = 1'b1;
            end
            CMD_TRAV: begin
              if (stat.empty) begin
                ctl.load_out   = 1'b1;
                ctl.out_status = ST_EMPTY;
                ctl.out_last   = 1'b1;
              end else begin
                ctl.walk_start = 1'b1;
                ctl.rd_en      = 1'b1;
                state_next     = S_EMIT;
              end
            end
          endcase
        end
      end
      S_EMIT: begin
        // Hand the fetched entry out and fetch the next while more remain
        if (stat.out_free) begin
          ctl.load_out = 1'b1;
          ctl.out_mem  = 1'b1;
          ctl.out_last = stat.walk_done;
          if (stat.walk_done) begin
            state_next = S_IDLE;
          end else begin
            ctl.rd_en     = 1'b1;
            ctl.rd_walk   = 1'b1;
            ctl.walk_step = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hdl/circular_queue.sv
// Circular queue of 32-bit signed values: top level joining controller and datapath.
//
// Channels: item (cmd, value) in, result (status, data, occupancy, last) out,
// each a valid/stall pair; a beat moves when valid is high and stall is low.
// Enqueue, size and every error case give one result beat, registered in the
// cycle after the item is taken. Dequeue gives one beat, passing through the
// entry memory read register and then the output register. Traverse gives
// one beat per held entry by the same path, the first from the head and the rest
// one per cycle while result_stall is low, with last set on the newest entry.
// A new item is taken once the previous item's final beat sits in the output
// register and that register is free or being drained in the same cycle, so
// enqueue, size and errors run at one item per cycle while result_stall is low;
// dequeue and traverse take no new item until their final beat is loaded, as the
// controller stays in its emit state, reading through the single read port.
// Reset empties the queue (head, tail and count to zero) and drops any
// pending result beat; no clearing pass is needed.
// While result_stall is high and a beat is held, that beat holds and no new
// item or traverse entry is taken.
`default_nettype none

module circular_queue import cq_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  cq_ctl_t  ctl;
  cq_stat_t stat;

  cq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (item.cmd),
    .stat       (stat),
    .ctl        (ctl)
  );

  cq_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .value        (item.value),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire
